/* sv/cltl_pkg.sv */
package cltl_pkg;

    // HD44780 instruction codes used by the layout logic.
    localparam logic [7:0] INSTR_HOME  = 8'h02;
    localparam logic [7:0] INSTR_DDRAM = 8'h80;

    // Rows two and three fold back into the first two address lines.
    localparam logic [7:0] ROW_FOLD = 8'h6C;

    // Character code that starts a new row without writing a character.
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    // Line length after reset.
    localparam logic [5:0] LINE_LENGTH_RESET = 6'd16;

    // Input command codes.
    localparam logic CMD_HOME = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    // Register-select codes on the bus.
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Index of the final nibble for a two-transfer and a four-transfer item.
    localparam logic [1:0] LAST_TWO  = 2'd1;
    localparam logic [1:0] LAST_FOUR = 2'd3;

    // Transfers owed for one item: up to two bytes, high nibble first.
    typedef struct packed {
        logic       rs0;
        logic [7:0] byte0;
        logic       rs1;
        logic [7:0] byte1;
        logic [1:0] last_idx;
    } t_job;

endpackage

/* sv/char_lcd_text_layout_4bit.sv */
// Text layout for a character LCD on a 4-bit HD44780 bus.
//
// Input channel (i_in_valid / o_in_stall): one item is a command bit and a
// character byte. A home item sends the cursor-home instruction; a character
// item may first send a set-DDRAM-address instruction (newline or full line)
// and then, unless it is a newline, the character as data.
// Output channel (o_out_valid / i_out_stall): one nibble per transfer, with
// register select, nibble and a last flag on the final transfer of an item.
// Each byte goes out as two transfers, high nibble first.
//
// An accepted item waits in the pending-item register; its nibbles then move
// into the output register. The output port, which sets the sustained rate,
// moves one nibble per cycle while not stalled, so an item takes two or four
// transfers. A new item is accepted in the same cycle in which the last nibble
// of the previous one moves into the output register: no bubble between items.
// A stalled output holds its transfer and the pending item; the input stays
// stalled until the last nibble of the pending item moves into the output
// register. Synchronous reset empties both stages, sets the line
// length to 16 and puts the cursor at column 0, row 0.
// The line length register may be written only while the block is idle.
module char_lcd_text_layout_4bit
    import cltl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_reg_select,
    output logic [3:0] o_nibble,
    output logic       o_last
);

    logic [5:0] r_line_length;
    logic [5:0] r_column;
    logic [7:0] r_row;
    logic       r_job_valid;
    t_job       r_job;
    logic [1:0] r_job_idx;
    logic       r_out_valid;
    logic       r_out_rs;
    logic [3:0] r_out_nibble;
    logic       r_out_last;

    t_job       n_job;
    logic [5:0] n_column;
    logic [7:0] n_row;

    logic       out_take;
    logic       out_free;
    logic       job_move;
    logic       job_done;
    logic       in_accept;
    logic       sel_rs;
    logic [7:0] sel_byte;
    logic [3:0] sel_nibble;

    // Layout decision for the item on the input port.
    cltl_step u_step (
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_column     (r_column),
        .i_row        (r_row),
        .i_line_length(r_line_length),
        .o_job        (n_job),
        .o_column     (n_column),
        .o_row        (n_row)
    );

    // Handshake between the pending item and the output register.
    assign out_take   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || out_take;
    assign job_move   = r_job_valid && out_free;
    assign job_done   = job_move && (r_job_idx == r_job.last_idx);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_job_valid && !job_done;

    // Pick the next nibble of the pending item.
    assign sel_rs     = r_job_idx[1] ? r_job.rs1 : r_job.rs0;
    assign sel_byte   = r_job_idx[1] ? r_job.byte1 : r_job.byte0;
    assign sel_nibble = r_job_idx[0] ? sel_byte[3:0] : sel_byte[7:4];

    // Configuration and layout state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RESET;
            r_column      <= 6'd0;
            r_row         <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_line_length <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_column <= n_column;
                r_row    <= n_row;
            end
        end
    end

    // Pending item: control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_idx   <= 2'd0;
        end else if (in_accept) begin
            r_job_valid <= 1'b1;
            r_job_idx   <= 2'd0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (job_move) begin
            r_job_idx <= r_job_idx + 2'd1;
        end
    end

    // Pending item: payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_job <= n_job;
        end
    end

    // Output register: control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (job_move) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge i_clk) begin
        if (job_move) begin
            r_out_rs     <= sel_rs;
            r_out_nibble <= sel_nibble;
            r_out_last   <= (r_job_idx == r_job.last_idx);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_nibble     = r_out_nibble;
    assign o_last       = r_out_last;

    // The nibble counter never runs past the final transfer of an item.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_idx <= r_job.last_idx))
        else $error("nibble index past end of item");

    // A home item yields exactly one instruction byte.
    a_home_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_command == CMD_HOME)) |=>
        (r_job_valid && (r_job.last_idx == LAST_TWO) && (r_job.rs0 == RS_INSTR)))
        else $error("home item decoded wrongly");

    // A transfer that is not final always has the rest of its item still pending.
    a_pair_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_job_valid)
        else $error("transfer sequence broken");

    // The input is never taken while an item still has nibbles left over.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_job_valid) |-> job_done)
        else $error("item accepted over a pending item");

endmodule

/* sv/cltl_step.sv */
module cltl_step
    import cltl_pkg::*;
(
    input  logic       i_command,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_column,
    input  logic [7:0] i_row,
    input  logic [5:0] i_line_length,
    output t_job       o_job,
    output logic [5:0] o_column,
    output logic [7:0] o_row
);

    logic       is_newline;
    logic       is_wrap;
    logic [7:0] row_next;
    logic [7:0] row_addr;

    assign is_newline = (i_char_code == NEWLINE_CODE);
    assign is_wrap    = (i_column == i_line_length);
    assign row_next   = i_row + 8'd1;

    // DDRAM base of the next row: 0x40 per row, folded back from row two on.
    always_comb begin
        row_addr = {row_next[1:0], 6'b0};
        if (row_next >= 8'd2) begin
            row_addr = row_addr - ROW_FOLD;
        end
    end

    // Work out the transfers for this item and the layout state after it.
    always_comb begin
        o_job.rs0      = RS_DATA;
        o_job.byte0    = i_char_code;
        o_job.rs1      = RS_DATA;
        o_job.byte1    = i_char_code;
        o_job.last_idx = LAST_TWO;
        o_column       = i_column + 6'd1;
        o_row          = i_row;
        if (i_command == CMD_HOME) begin
            o_job.rs0   = RS_INSTR;
            o_job.byte0 = INSTR_HOME;
            o_column    = 6'd0;
            o_row       = 8'd0;
        end else if (is_newline || is_wrap) begin
            o_job.rs0   = RS_INSTR;
            o_job.byte0 = INSTR_DDRAM | row_addr;
            o_row       = row_next;
            if (is_newline) begin
                o_column = 6'd0;
            end else begin
                o_job.last_idx = LAST_FOUR;
                o_column       = 6'd1;
            end
        end
    end

endmodule
